@@ src/hrsp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, codes and the digit decode for the hex record stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

   // Record field position of the parser
   typedef enum logic [3:0] {
      PH_COLON   = 4'd0,
      PH_LEN     = 4'd1,
      PH_ADDR_HI = 4'd2,
      PH_ADDR_LO = 4'd3,
      PH_TYPE    = 4'd4,
      PH_DATA    = 4'd5,
      PH_CKSUM   = 4'd6,
      PH_SEP     = 4'd7,
      PH_HALT    = 4'd8
   } phase_type;

   // Result kinds
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_SYNC  = 2'd2;

   // Characters and record codes
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] ALPHA_OFFSET = 8'd55;
   localparam logic [7:0] TYPE_DATA    = 8'h00;
   localparam logic [7:0] TYPE_EOF     = 8'h01;

   // Parser state carried from one character to the next
   typedef struct packed {
      phase_type   phase;
      logic        digit_half;
      logic [7:0]  high_value;
      logic [7:0]  bytes_left;
      logic [15:0] record_address;
      logic [7:0]  record_type;
   } parse_state_type;

   // One result of the parser
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [15:0] write_address;
      logic [7:0]  write_data;
   } parse_result_type;

   // Map a character to its digit value, mod 256
   function automatic logic [7:0] map_digit(input logic [7:0] c);
      logic [7:0] value;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         value = c - CHAR_ZERO;
      end else begin
         value = c - ALPHA_OFFSET;
      end
      return value;
   endfunction

endpackage

@@ src/hex_record_stream_parser_core.sv @@
// ----------------------------------------------------------------------------
// hex_record_stream_parser_core
// Hex record character stream parser: emits data writes, end and sync errors.
// ----------------------------------------------------------------------------
// Path: a character passes the input register, then the result register,
//   before its result shows on rsp_valid. One character per cycle unless
//   rsp_stall holds a result; the parser state updates in one step.
// Reset: synchronous, clears both valid flags and returns the parser to
//   waiting for a colon; payload registers are not reset.
module hex_record_stream_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_write_address,
   output logic [7:0]  rsp_write_data
);

   logic                       in_vld_ff;
   logic [7:0]                 in_char_ff;
   hrsp_pkg::parse_state_type  state_ff;
   hrsp_pkg::parse_state_type  state_in;
   hrsp_pkg::parse_result_type step_result;
   logic                       out_vld_ff;
   logic [1:0]                 out_kind_ff;
   logic [15:0]                out_address_ff;
   logic [7:0]                 out_data_ff;
   logic                       proc_go;

   // Process the held character when the result register can take a transfer
   assign proc_go   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !proc_go;

   hrsp_step u_step (
      .cur_state (state_ff),
      .char_in   (in_char_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         in_vld_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_char_ff <= req_char_in;
      end
   end

   // Parser state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= hrsp_pkg::PH_COLON;
         state_ff.digit_half     <= 1'b0;
         state_ff.high_value     <= 8'd0;
         state_ff.bytes_left     <= 8'd0;
         state_ff.record_address <= 16'd0;
         state_ff.record_type    <= 8'd0;
      end else if (proc_go) begin
         state_ff <= state_in;
      end
   end

   // Result register: load on a produced result, clear once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (proc_go) begin
         out_vld_ff <= step_result.valid;
      end else if (out_vld_ff && !rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
      if (proc_go && step_result.valid) begin
         out_kind_ff    <= step_result.kind;
         out_address_ff <= step_result.write_address;
         out_data_ff    <= step_result.write_data;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_write_address = out_address_ff;
   assign rsp_write_data    = out_data_ff;

endmodule

@@ src/hrsp_step.sv @@
// ----------------------------------------------------------------------------
// hrsp_step
// Next parser state and optional result for one record character.
// ----------------------------------------------------------------------------
module hrsp_step (
   input  hrsp_pkg::parse_state_type  cur_state,
   input  logic [7:0]                 char_in,
   output hrsp_pkg::parse_state_type  nxt_state,
   output hrsp_pkg::parse_result_type result
);

   logic [7:0] byte_value;
   logic [7:0] bytes_dec;

   // Assemble the byte from the stored high digit and this low digit
   assign byte_value = {cur_state.high_value[3:0], 4'b0000} + hrsp_pkg::map_digit(char_in);
   assign bytes_dec  = cur_state.bytes_left - 8'd1;

   always_comb begin
      nxt_state            = cur_state;
      result.valid         = 1'b0;
      result.kind          = hrsp_pkg::KIND_WRITE;
      result.write_address = 16'd0;
      result.write_data    = 8'd0;

      case (cur_state.phase)
         hrsp_pkg::PH_HALT: begin
            // drop every character until reset
         end
         hrsp_pkg::PH_COLON: begin
            if (char_in == hrsp_pkg::CHAR_COLON) begin
               nxt_state.phase      = hrsp_pkg::PH_LEN;
               nxt_state.digit_half = 1'b0;
            end else begin
               nxt_state.phase = hrsp_pkg::PH_HALT;
               result.valid    = 1'b1;
               result.kind     = hrsp_pkg::KIND_SYNC;
            end
         end
         hrsp_pkg::PH_SEP: begin
            nxt_state.phase = hrsp_pkg::PH_COLON;
         end
         hrsp_pkg::PH_LEN, hrsp_pkg::PH_ADDR_HI, hrsp_pkg::PH_ADDR_LO,
         hrsp_pkg::PH_TYPE, hrsp_pkg::PH_DATA, hrsp_pkg::PH_CKSUM: begin
            if (!cur_state.digit_half) begin
               // hold the high digit
               nxt_state.high_value = hrsp_pkg::map_digit(char_in);
               nxt_state.digit_half = 1'b1;
            end else begin
               nxt_state.digit_half = 1'b0;
               case (cur_state.phase)
                  hrsp_pkg::PH_LEN: begin
                     nxt_state.bytes_left = byte_value;
                     nxt_state.phase      = hrsp_pkg::PH_ADDR_HI;
                  end
                  hrsp_pkg::PH_ADDR_HI: begin
                     nxt_state.record_address = {byte_value, 8'h00};
                     nxt_state.phase          = hrsp_pkg::PH_ADDR_LO;
                  end
                  hrsp_pkg::PH_ADDR_LO: begin
                     nxt_state.record_address = {cur_state.record_address[15:8], byte_value};
                     nxt_state.phase          = hrsp_pkg::PH_TYPE;
                  end
                  hrsp_pkg::PH_TYPE: begin
                     nxt_state.record_type = byte_value;
                     if (byte_value == hrsp_pkg::TYPE_EOF) begin
                        nxt_state.phase = hrsp_pkg::PH_HALT;
                        result.valid    = 1'b1;
                        result.kind     = hrsp_pkg::KIND_END;
                     end else if (cur_state.bytes_left != 8'd0) begin
                        nxt_state.phase = hrsp_pkg::PH_DATA;
                     end else begin
                        nxt_state.phase = hrsp_pkg::PH_CKSUM;
                     end
                  end
                  hrsp_pkg::PH_DATA: begin
                     // emit a write for data records and advance the address
                     if (cur_state.record_type == hrsp_pkg::TYPE_DATA) begin
                        result.valid             = 1'b1;
                        result.kind              = hrsp_pkg::KIND_WRITE;
                        result.write_address     = cur_state.record_address;
                        result.write_data        = byte_value;
                        nxt_state.record_address = cur_state.record_address + 16'd1;
                     end
                     nxt_state.bytes_left = bytes_dec;
                     if (bytes_dec == 8'd0) begin
                        nxt_state.phase = hrsp_pkg::PH_CKSUM;
                     end
                  end
                  hrsp_pkg::PH_CKSUM: begin
                     nxt_state.phase = hrsp_pkg::PH_SEP;
                  end
                  default: begin
                     nxt_state.phase = hrsp_pkg::PH_HALT;
                  end
               endcase
            end
         end
         default: begin
            // unused encodings behave as halted
            nxt_state.phase = hrsp_pkg::PH_HALT;
         end
      endcase
   end

endmodule
